/* design/chtbl_pkg.sv */
// ----------------------------------------------------------------------------
// chtbl_pkg
// Shared types, sizes and helper functions for the checked handle table.
// ----------------------------------------------------------------------------
package chtbl_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned REF_BITS      = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned HANDLE_W      = 32;

  // Widths of the result fields on the output stream.
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned OUT_REF_W = 16;

  // Saturation value of a reference count.
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  // Operation codes carried with each request.
  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_GET     = 2'd1,
    MODE_PUT     = 2'd2,
    MODE_DESTROY = 2'd3
  } mode_e;

  // Life cycle of one entry.
  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_PENDING = 2'd1,
    ST_ACTIVE  = 2'd2
  } ent_state_e;

  // Result status codes.
  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_BAD  = 2'd1,
    RS_FULL = 2'd2,
    RS_OVF  = 2'd3
  } status_e;

  // Tag and count of one entry as held in the entry memory.
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [REF_BITS-1:0] refs;
  } ent_word_t;

  // Update of one entry's state, issued when a request completes.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    ent_state_e       st;
  } st_upd_t;

  // What the state array shows to the execute logic.
  typedef struct packed {
    logic             any_empty;
    logic [IDX_W-1:0] free_idx;
    ent_state_e       st;
  } st_view_t;

  // Low bits of a reference count as reported on the output.
  function automatic logic [OUT_REF_W-1:0] refs_to_out(logic [REF_BITS-1:0] r);
    logic [31:0] w;
    w = 32'(r);
    return w[OUT_REF_W-1:0];
  endfunction

  // Low bits of an entry index as reported on the output.
  function automatic logic [OUT_IDX_W-1:0] idx_to_out(logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

/* design/chtbl_ram.sv */
// ----------------------------------------------------------------------------
// chtbl_ram
// Simple dual-port RAM: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module chtbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* design/chtbl_state.sv */
// ----------------------------------------------------------------------------
// chtbl_state
// Per-entry life-cycle state, lowest-free-entry search and indexed lookup.
// ----------------------------------------------------------------------------
module chtbl_state
  import chtbl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  st_upd_t          upd_i,
  input  logic [IDX_W-1:0] look_idx_i,
  output st_view_t         view_o
);

  ent_state_e st_q [TABLE_ENTRIES];

  // Every entry starts empty; a completed request may change one entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        st_q[i] <= ST_EMPTY;
      end
    end else if (upd_i.we) begin
      st_q[upd_i.idx] <= upd_i.st;
    end
  end

  // Priority encoder: the lowest empty entry wins. The state of the entry
  // addressed by the request under execution is looked up alongside.
  always_comb begin
    view_o.any_empty = 1'b0;
    view_o.free_idx  = '0;
    view_o.st        = st_q[look_idx_i];
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (st_q[i] == ST_EMPTY) begin
        view_o.any_empty = 1'b1;
        view_o.free_idx  = IDX_W'(i);
      end
    end
  end

  // An update is visible on the following cycle.
  a_upd_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.we |=> st_q[$past(upd_i.idx)] == $past(upd_i.st))
    else $error("entry state update was not stored");

endmodule

/* design/checked_handle_table_core.sv */
// ----------------------------------------------------------------------------
// checked_handle_table_core
// Table of checked handles with reference counts, one request per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation
// (create, get, put, destroy) and tdata the handle index, the handle check
// tag and the tag to store on create. Every request yields exactly one
// result on the m_axis channel: tuser carries the status and tdata the
// entry index, the entry tag, the released flag and the reference count.
// A request is taken into an input register while the entry memory is
// read; once the output register is free it executes, and its result is
// loaded into the output register, which offers it on m_axis.
// A new request can be accepted every cycle while the receiver takes
// results; a write to the same entry by the request just ahead is
// forwarded into the read path.
// When the receiver stalls, the output register holds its result, the
// input register keeps its request, and s_axis_tready drops once both
// are full. Reset marks every entry empty at once; stale memory contents
// behind an empty entry are never used, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module checked_handle_table_core
  import chtbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] handle_index, [63:32] handle_check, [95:64] new_tag
  input  logic [95:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] out_index, [37:6] out_check, [38] released, [54:39] ref_count,
  // [55] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  // Input register.
  logic                s1_valid_q;
  mode_e               s1_mode_q;
  logic [HANDLE_W-1:0] s1_index_q;
  logic [TAG_W-1:0]    s1_check_q;
  logic [TAG_W-1:0]    s1_tag_q;
  logic                byp_q, byp_d;
  ent_word_t           byp_word_q;

  // Output register.
  logic                 out_valid_q;
  status_e              out_status_q, out_status_d;
  logic [OUT_IDX_W-1:0] out_index_q, out_index_d;
  logic [TAG_W-1:0]     out_check_q, out_check_d;
  logic                 out_rel_q, out_rel_d;
  logic [OUT_REF_W-1:0] out_refs_q, out_refs_d;

  logic s_accept;
  logic s1_fire;

  // Entry memory and state.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ent_word_t        ram_wdata;
  ent_word_t        ram_rdata;
  st_upd_t          st_upd;
  st_view_t         st_view;

  // Entry as seen by the request under execution.
  ent_word_t           ent_word;
  logic [TAG_W-1:0]    ent_tag;
  logic [REF_BITS-1:0] ent_refs;
  logic [REF_BITS-1:0] refs_dec;
  logic                in_range;
  logic [IDX_W-1:0]    s1_idx;

  // Handshake: the input register moves on when the output is free.
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Forward a write to the entry that the incoming request reads.
  assign byp_d = ram_we && (ram_waddr == s_axis_tdata[IDX_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_mode_q  <= mode_e'(s_axis_tuser);
      s1_index_q <= s_axis_tdata[31:0];
      s1_check_q <= s_axis_tdata[63:32];
      s1_tag_q   <= s_axis_tdata[95:64];
      byp_q      <= byp_d;
      byp_word_q <= ram_wdata;
    end
  end

  chtbl_ram #(
    .WIDTH($bits(ent_word_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (s_accept),
    .raddr_i(s_axis_tdata[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign s1_idx = s1_index_q[IDX_W-1:0];

  chtbl_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (st_upd),
    .look_idx_i(s1_idx),
    .view_o    (st_view)
  );

  // An empty entry reads as a zero tag and a zero count.
  assign ent_word = byp_q ? byp_word_q : ram_rdata;
  assign ent_tag  = (st_view.st != ST_EMPTY) ? ent_word.tag : '0;
  assign ent_refs = (st_view.st != ST_EMPTY) ? ent_word.refs : '0;
  assign refs_dec = ent_refs - REF_BITS'(1);
  assign in_range = s1_index_q < HANDLE_W'(TABLE_ENTRIES);

  // Execute: check the handle, update the entry and build the result.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = s1_idx;
    ram_wdata     = '{tag: ent_tag, refs: ent_refs};
    st_upd.we     = 1'b0;
    st_upd.idx    = s1_idx;
    st_upd.st     = st_view.st;
    out_status_d  = RS_BAD;
    out_index_d   = s1_index_q[OUT_IDX_W-1:0];
    out_check_d   = '0;
    out_rel_d     = 1'b0;
    out_refs_d    = '0;
    case (s1_mode_q)
      MODE_CREATE: begin
        if (!st_view.any_empty) begin
          out_status_d = RS_FULL;
          out_index_d  = '0;
        end else begin
          ram_we       = s1_fire;
          ram_waddr    = st_view.free_idx;
          ram_wdata    = '{tag: s1_tag_q, refs: REF_BITS'(1)};
          st_upd.we    = s1_fire;
          st_upd.idx   = st_view.free_idx;
          st_upd.st    = ST_ACTIVE;
          out_status_d = RS_OK;
          out_index_d  = idx_to_out(st_view.free_idx);
          out_check_d  = s1_tag_q;
          out_refs_d   = OUT_REF_W'(1);
        end
      end
      MODE_GET: begin
        if (in_range && st_view.st == ST_ACTIVE && ent_tag == s1_check_q) begin
          out_check_d = ent_tag;
          if (ent_refs == REF_MAX) begin
            out_status_d = RS_OVF;
            out_refs_d   = refs_to_out(ent_refs);
          end else begin
            ram_we       = s1_fire;
            ram_wdata    = '{tag: ent_tag, refs: ent_refs + REF_BITS'(1)};
            out_status_d = RS_OK;
            out_refs_d   = refs_to_out(ent_refs + REF_BITS'(1));
          end
        end
      end
      MODE_PUT, MODE_DESTROY: begin
        if (in_range && ent_tag == s1_check_q && ent_refs != '0) begin
          out_status_d = RS_OK;
          out_check_d  = ent_tag;
          st_upd.we    = s1_fire;
          if (refs_dec == '0) begin
            // Last reference gone: the entry is freed.
            st_upd.st = ST_EMPTY;
            out_rel_d = 1'b1;
          end else begin
            ram_we     = s1_fire;
            ram_wdata  = '{tag: ent_tag, refs: refs_dec};
            st_upd.st  = (s1_mode_q == MODE_DESTROY) ? ST_PENDING : st_view.st;
            out_refs_d = refs_to_out(refs_dec);
          end
        end
      end
      default: begin
        out_status_d = RS_BAD;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_check_q  <= out_check_d;
      out_rel_q    <= out_rel_d;
      out_refs_q   <= out_refs_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_refs_q, out_rel_q, out_check_q, out_index_q};

  // No entry changes unless a request completes.
  a_no_stray_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |-> !ram_we && !st_upd.we)
    else $error("entry written without a completing request");

  // A released entry reports success with a zero count.
  a_release_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rel_q |-> out_status_q == RS_OK && out_refs_q == '0)
    else $error("released result with bad status or count");

  // Back pressure only when both registers are occupied and the sink stalls.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q && !m_axis_tready)
    else $error("request refused with room in the pipeline");

endmodule
